// ===== rtl/minimal_tuner_set_cover_macros.svh =====
// Assertion helpers for the checker file.
`ifndef MINIMAL_TUNER_SET_COVER_MACROS_SVH
`define MINIMAL_TUNER_SET_COVER_MACROS_SVH

// Clocked property, switched off while reset is high.
`define MTSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define MTSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mtsc_pkg.sv =====
package mtsc_pkg;

  // Widths fixed by the channel formats.
  localparam int MASK_W  = 8;
  localparam int COUNT_W = 4;
  localparam int SIZE_W  = 4;

  // Default capacities.
  localparam int MAX_TUNERS_DEF   = 8;
  localparam int MAX_CHANNELS_DEF = 256;

  typedef struct packed {
    logic              found;
    logic [MASK_W-1:0] cover_mask;
    logic [SIZE_W-1:0] cover_size;
  } res_t;

endpackage

// ===== rtl/mtsc_ifs.sv =====
interface mtsc_item_if;
  logic                       valid;
  logic                       ready;
  logic [mtsc_pkg::MASK_W-1:0] tuner_mask;
  logic                       last_entry;

  modport source (output valid, output tuner_mask, output last_entry, input ready);
  modport sink (input valid, input tuner_mask, input last_entry, output ready);
endinterface

interface mtsc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mtsc_pkg::MASK_W-1:0] cover_mask;
  logic [mtsc_pkg::SIZE_W-1:0] cover_size;

  modport source (output valid, output found, output cover_mask, output cover_size,
                  input ready);
  modport sink (input valid, input found, input cover_mask, input cover_size,
                output ready);
endinterface

interface mtsc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mtsc_pkg::COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mtsc_lineup_ram.sv =====
module mtsc_lineup_ram #(
  parameter int DEPTH = mtsc_pkg::MAX_CHANNELS_DEF,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [mtsc_pkg::MASK_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [mtsc_pkg::MASK_W-1:0] rd_data
);

  logic [mtsc_pkg::MASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/mtsc_search.sv =====
module mtsc_search #(
  parameter int MAX_TUNERS   = mtsc_pkg::MAX_TUNERS_DEF,
  parameter int MAX_CHANNELS = mtsc_pkg::MAX_CHANNELS_DEF,
  parameter int AW           = 8,
  parameter int CW           = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mtsc_pkg::MASK_W-1:0]  in_mask,
  input  logic                         in_last,
  input  logic [mtsc_pkg::COUNT_W-1:0] tuner_num,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [mtsc_pkg::MASK_W-1:0]  ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [mtsc_pkg::MASK_W-1:0]  ram_rdata,
  output logic                         res_valid,
  input  logic                         res_take,
  output mtsc_pkg::res_t               res
);

  // Tuners beyond the mask width can never be named, so the search width stops there.
  localparam int TW = (MAX_TUNERS < mtsc_pkg::MASK_W) ? MAX_TUNERS : mtsc_pkg::MASK_W;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_CAND = 4'b0010,
    S_SCAN = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  function automatic logic [mtsc_pkg::SIZE_W-1:0] ones(input logic [TW-1:0] x);
    logic [mtsc_pkg::SIZE_W-1:0] s;
    s = '0;
    for (int i = 0; i < TW; i++) begin
      s = s + mtsc_pkg::SIZE_W'(x[i]);
    end
    return s;
  endfunction

  state_t                      state;
  logic [CW-1:0]               total;
  logic [CW-1:0]               addr;
  logic                        rd_valid;
  logic [TW-1:0]               v;
  logic [TW-1:0]               cand;
  logic [mtsc_pkg::SIZE_W-1:0] k;

  logic [mtsc_pkg::COUNT_W-1:0] n;
  logic [TW-1:0]                pres;
  logic [TW-1:0]                cset;
  logic                         cset_ok;
  logic                         issue;
  logic                         miss;
  logic                         accept;
  logic                         room;

  always_comb begin
    n = (tuner_num > mtsc_pkg::COUNT_W'(TW)) ? mtsc_pkg::COUNT_W'(TW) : tuner_num;
    for (int i = 0; i < TW; i++) begin
      pres[i] = (mtsc_pkg::COUNT_W'(i) < n);
      // Counter bit TW-1 is tuner 0, so counting down walks each size in
      // lexicographic order of ascending tuner indices.
      cset[i] = v[TW-1-i];
    end
    cset_ok = ((cset & ~pres) == '0) && (ones(cset) == k);
  end

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_LOAD);
  assign res_valid = (state == S_HOLD);
  assign room      = (total < CW'(MAX_CHANNELS));
  assign issue     = (addr != total);
  assign miss      = rd_valid && ((ram_rdata & mtsc_pkg::MASK_W'(cand)) == '0);

  assign ram_we    = accept && room;
  assign ram_waddr = total[AW-1:0];
  assign ram_wdata = in_mask & mtsc_pkg::MASK_W'(pres);
  assign ram_raddr = addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      total    <= '0;
      addr     <= '0;
      rd_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              total <= total + CW'(1);
            end
            if (in_last) begin
              if (n == '0) begin
                res   <= '0;
                total <= '0;
                state <= S_HOLD;
              end else begin
                k     <= mtsc_pkg::SIZE_W'(1);
                v     <= '1;
                state <= S_CAND;
              end
            end
          end
        end
        S_CAND: begin
          if (cset_ok) begin
            cand     <= cset;
            addr     <= '0;
            rd_valid <= 1'b0;
            state    <= S_SCAN;
          end else if (v == '0) begin
            if (k >= mtsc_pkg::SIZE_W'(n)) begin
              res   <= '0;
              total <= '0;
              state <= S_HOLD;
            end else begin
              k <= k + mtsc_pkg::SIZE_W'(1);
              v <= '1;
            end
          end else begin
            v <= v - TW'(1);
          end
        end
        S_SCAN: begin
          if (miss) begin
            // A channel this set cannot receive; drop the pending read.
            v        <= v - TW'(1);
            rd_valid <= 1'b0;
            state    <= S_CAND;
          end else if (!issue && !rd_valid) begin
            res.found      <= 1'b1;
            res.cover_mask <= mtsc_pkg::MASK_W'(cand);
            res.cover_size <= k;
            total          <= '0;
            state          <= S_HOLD;
          end else begin
            if (issue) begin
              addr <= addr + CW'(1);
            end
            rd_valid <= issue;
          end
        end
        S_HOLD: begin
          if (res_take) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/minimal_tuner_set_cover.sv =====
// Minimal tuner set cover.
// Channels: cfg writes the tuner count (tuners 0..count-1 present, count capped
// at W); items carries one lineup entry per transfer (tuner_mask, last_entry);
// results returns found, cover_mask and cover_size for each lineup.
// Items.ready stays high while loading.
// The transfer marked last starts the search and items.ready drops until the
// result moves into the output register. The search walks sizes 1..T (T the
// present tuner count) and counts a W-bit candidate register (W = MAX_TUNERS
// capped at the mask width) down through all 2^W values per size; a candidate
// of the right size that names only present tuners is checked by streaming the
// stored lineup out of the channel RAM, one entry per cycle. A search stops at
// the first cover. The result waits in the output register while the receiver
// stalls, and the next lineup may load meanwhile; a second result waits in the
// search unit. Reset empties the lineup, clears the tuner count to zero and
// drops any result. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module minimal_tuner_set_cover #(
  parameter int MAX_TUNERS   = mtsc_pkg::MAX_TUNERS_DEF,
  parameter int MAX_CHANNELS = mtsc_pkg::MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mtsc_cfg_if.sink      cfg,
  mtsc_item_if.sink     items,
  mtsc_result_if.source results
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  logic [mtsc_pkg::COUNT_W-1:0] tuner_num;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [mtsc_pkg::MASK_W-1:0]  ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [mtsc_pkg::MASK_W-1:0]  ram_rdata;
  logic                         res_valid;
  logic                         res_take;
  mtsc_pkg::res_t               res;
  mtsc_pkg::res_t               out_q;
  logic                         out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tuner_num <= '0;
    end else if (cfg.valid) begin
      tuner_num <= cfg.data;
    end
  end

  mtsc_lineup_ram #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  mtsc_search #(
    .MAX_TUNERS   (MAX_TUNERS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW),
    .CW           (CW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_mask   (items.tuner_mask),
    .in_last   (items.last_entry),
    .tuner_num (tuner_num),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign results.valid      = out_valid;
  assign results.found      = out_q.found;
  assign results.cover_mask = out_q.cover_mask;
  assign results.cover_size = out_q.cover_size;

endmodule

// ===== rtl/mtsc_checker.sv =====
`include "minimal_tuner_set_cover_macros.svh"

module mtsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [mtsc_pkg::MASK_W-1:0] cover_mask,
  input logic [mtsc_pkg::SIZE_W-1:0] cover_size
);

  `MTSC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(cover_mask) && $stable(cover_size) && $stable(found), "result changed while stalled")
  `MTSC_ASSERT(a_miss_empty, clk, rst, out_valid && !found |-> cover_mask == '0 && cover_size == '0, "no-cover result carries a set")
  `MTSC_ASSERT(a_size_match, clk, rst, out_valid && found |-> $countones(cover_mask) == cover_size && cover_size != '0, "cover size disagrees with mask")
  `MTSC_ASSERT(a_busy_after_last, clk, rst, in_valid && in_ready && in_last |=> !in_ready, "input taken during search")
  `MTSC_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid, "result valid right after reset")

endmodule

bind minimal_tuner_set_cover mtsc_checker u_mtsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .in_last    (items.last_entry),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .found      (results.found),
  .cover_mask (results.cover_mask),
  .cover_size (results.cover_size)
);

// ===== dv/minimal_tuner_set_cover_tb.sv =====
`timescale 1ns / 100ps

module minimal_tuner_set_cover_tb;

  localparam int N_ITEMS   = 650;
  localparam int N_PLAN    = 21;
  localparam int TUNER_CAP = (mtsc_pkg::MAX_TUNERS_DEF < mtsc_pkg::MASK_W) ?
                             mtsc_pkg::MAX_TUNERS_DEF : mtsc_pkg::MASK_W;

  // One row of the directed lineup plan. When load_count is set, the tuner count
  // is written (with the block idle) before the channel is sent.
  typedef struct packed {
    logic                         load_count;
    logic [mtsc_pkg::COUNT_W-1:0] count;
    logic [mtsc_pkg::MASK_W-1:0]  mask;
    logic                         last;
    logic                         typed;
    logic                         want_found;
    logic [mtsc_pkg::MASK_W-1:0]  want_mask;
    logic [mtsc_pkg::SIZE_W-1:0]  want_size;
  } plan_row_t;

  localparam logic [mtsc_pkg::COUNT_W-1:0] COUNT_CHOICES [12] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd8, 4'd15
  };

  plan_row_t channel_plan [N_PLAN] = '{
    '{1'b0, 4'd0,  8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 4'd0},  // no tuners after reset
    '{1'b1, 4'd8,  8'hFF, 1'b1, 1'b1, 1'b1, 8'h01, 4'd1},
    '{1'b0, 4'd0,  8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 4'd0},  // channel nobody receives
    '{1'b1, 4'd3,  8'hF8, 1'b1, 1'b1, 1'b0, 8'h00, 4'd0},  // only absent tuners named
    '{1'b1, 4'd8,  8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h04, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h08, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h10, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h40, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h80, 1'b1, 1'b1, 1'b1, 8'hFF, 4'd8},
    '{1'b1, 4'd15, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},  // count above capacity
    '{1'b0, 4'd0,  8'h01, 1'b1, 1'b1, 1'b1, 8'h81, 4'd2},
    '{1'b1, 4'd1,  8'h01, 1'b1, 1'b1, 1'b1, 8'h01, 4'd1},
    '{1'b1, 4'd4,  8'h03, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h06, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h0C, 1'b1, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b1, 4'd8,  8'hA5, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b0, 4'd0,  8'h5A, 1'b1, 1'b0, 1'b0, 8'h00, 4'd0},
    '{1'b1, 4'd0,  8'h55, 1'b1, 1'b1, 1'b0, 8'h00, 4'd0}
  };

  logic clk = 1'b0;
  logic rst;

  mtsc_cfg_if    cfg_ch ();
  mtsc_item_if   item_ch ();
  mtsc_result_if result_ch ();

  minimal_tuner_set_cover dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (result_ch)
  );

  logic [mtsc_pkg::COUNT_W-1:0] tuner_num_cfg;
  logic [mtsc_pkg::MASK_W-1:0]  lineup_q [$];
  mtsc_pkg::res_t               cover_q [$];
  int                           items_sent;
  int                           mismatch_count;
  bit                           steady_run;

  always #6 clk = ~clk;

  // Smallest covering tuner set over the stored lineup, sizes ascending and
  // combinations in lexicographic order of their sorted tuner indices.
  function automatic mtsc_pkg::res_t min_cover(input int n);
    mtsc_pkg::res_t              best;
    int                          pick [mtsc_pkg::MASK_W];
    int                          k;
    int                          i;
    logic [mtsc_pkg::MASK_W-1:0] cand;
    bit                          hit;
    bit                          more;
    best = '0;
    for (k = 1; k <= n; k++) begin
      for (i = 0; i < k; i++) pick[i] = i;
      more = 1'b1;
      while (more) begin
        cand = '0;
        for (i = 0; i < k; i++) cand[pick[i]] = 1'b1;
        hit = 1'b1;
        foreach (lineup_q[c]) begin
          if ((lineup_q[c] & cand) == '0) hit = 1'b0;
        end
        if (hit) begin
          best.found      = 1'b1;
          best.cover_mask = cand;
          best.cover_size = mtsc_pkg::SIZE_W'(k);
          return best;
        end
        i = k;
        while (i > 0 && pick[i-1] >= n - k + i - 1) i--;
        if (i == 0) begin
          more = 1'b0;
        end else begin
          pick[i-1]++;
          while (i < k) begin
            pick[i] = pick[i-1] + 1;
            i++;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic logic [mtsc_pkg::MASK_W-1:0] random_channel_mask();
    int                          kind;
    logic [mtsc_pkg::MASK_W-1:0] m;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      m = mtsc_pkg::MASK_W'(1) << $urandom_range(0, mtsc_pkg::MASK_W - 1);
      if ($urandom_range(0, 1) == 1) begin
        m = m | (mtsc_pkg::MASK_W'(1) << $urandom_range(0, mtsc_pkg::MASK_W - 1));
      end
    end else if (kind < 90) begin
      m = mtsc_pkg::MASK_W'($urandom);
    end else if (kind < 95) begin
      m = '0;
    end else begin
      m = '1;
    end
    return m;
  endfunction

  task automatic send_channel(input logic [mtsc_pkg::MASK_W-1:0] mask, input logic last,
                              input bit typed, input mtsc_pkg::res_t typed_res);
    int n;
    while (!steady_run && $urandom_range(0, 99) < 36) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.tuner_mask <= mask;
    item_ch.last_entry <= last;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    steady_run = (items_sent >= 300 && items_sent < 420);
    n = (tuner_num_cfg > TUNER_CAP) ? TUNER_CAP : int'(tuner_num_cfg);
    if (lineup_q.size() < mtsc_pkg::MAX_CHANNELS_DEF) begin
      lineup_q.insert(lineup_q.size(), mask & mtsc_pkg::MASK_W'((1 << n) - 1));
    end
    if (last) begin
      cover_q.insert(cover_q.size(), typed ? typed_res : min_cover(n));
      lineup_q.delete();
    end
  endtask

  task automatic wait_lineup_drained();
    item_ch.valid <= 1'b0;
    while (cover_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tuner_num(input logic [mtsc_pkg::COUNT_W-1:0] count);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= count;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tuner_num_cfg = count;
  endtask

  always @(posedge clk) begin
    mtsc_pkg::res_t got;
    mtsc_pkg::res_t want;
    result_ch.ready <= steady_run || ($urandom_range(0, 99) >= 36);
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.found, result_ch.cover_mask, result_ch.cover_size};
      if (cover_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no result, got found=%0b mask=%02h size=%0d", $realtime,
                 got.found, got.cover_mask, got.cover_size);
      end else begin
        want = cover_q.pop_front();
        if (got.found !== want.found || got.cover_mask !== want.cover_mask ||
            got.cover_size !== want.cover_size) begin
          mismatch_count++;
          $display("%0t: expected found=%0b mask=%02h size=%0d, %s", $realtime,
                   want.found, want.cover_mask, want.cover_size,
                   $sformatf("got found=%0b mask=%02h size=%0d",
                             got.found, got.cover_mask, got.cover_size));
        end
      end
    end
  end

  initial begin
    int                          lineup_no;
    int                          span;
    int                          j;
    logic [mtsc_pkg::MASK_W-1:0] ch_mask;
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.tuner_mask <= '0;
    item_ch.last_entry <= 1'b0;
    tuner_num_cfg      = '0;
    items_sent         = 0;
    mismatch_count     = 0;
    steady_run         = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (channel_plan[r]) begin
      if (channel_plan[r].load_count) begin
        wait_lineup_drained();
        write_tuner_num(channel_plan[r].count);
      end
      send_channel(channel_plan[r].mask, channel_plan[r].last, channel_plan[r].typed,
                   mtsc_pkg::res_t'({channel_plan[r].want_found, channel_plan[r].want_mask,
                                     channel_plan[r].want_size}));
    end

    lineup_no = 0;
    while (items_sent < N_ITEMS) begin
      if (lineup_no == 8) begin
        // Overlong lineup: the stored part always has a cover, the dropped tail
        // holds only channels nobody receives.
        wait_lineup_drained();
        write_tuner_num(4'd8);
        span = $urandom_range(mtsc_pkg::MAX_CHANNELS_DEF + 1, mtsc_pkg::MAX_CHANNELS_DEF + 24);
        for (j = 0; j < span; j++) begin
          ch_mask = '0;
          if (j < mtsc_pkg::MAX_CHANNELS_DEF) begin
            ch_mask = random_channel_mask() |
                      (mtsc_pkg::MASK_W'(1) << $urandom_range(0, 7));
          end
          send_channel(ch_mask, j == span - 1, 1'b0, '0);
        end
      end else begin
        if ($urandom_range(0, 99) < 20) begin
          wait_lineup_drained();
          write_tuner_num(COUNT_CHOICES[$urandom_range(0, 11)]);
        end
        span = $urandom_range(1, 10);
        for (j = 0; j < span; j++) begin
          send_channel(random_channel_mask(), j == span - 1, 1'b0, '0);
        end
      end
      lineup_no++;
    end

    item_ch.valid <= 1'b0;
    while (cover_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
